FILE: src/midpoint_ellipse_rasterizer_top_assert.svh
// assertion macros for the midpoint ellipse rasterizer
// used by the top level only, no other dependencies
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_TOP_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_TOP_ASSERT_SVH

// condition must never hold while out of reset
`define MER_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define MER_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: src/mer_pkg.sv
// shared types, constants and microcode rom for the ellipse rasterizer
// no dependencies
package mer_pkg;

    localparam int DEF_MAX_RADIUS = 31;
    localparam int DEF_COORD_BITS = 11;
    localparam int EXT_W          = 17;   // widest coordinate plus one
    localparam int RAD_W          = 5;
    localparam int OUT_W          = 12;
    localparam int OFF_W          = 6;
    localparam int Y_W            = 7;
    localparam int SQ_W           = 10;
    localparam int MUL_W          = 13;
    localparam int PROD_W         = 26;
    localparam int P_W            = 26;
    localparam int SLOPE_W        = 18;
    localparam int RESULT_LIMIT   = 64;
    localparam int CNT_W          = $clog2(RESULT_LIMIT + 1);
    localparam int UCODE_DEPTH    = 13;
    localparam int STEP_W         = $clog2(UCODE_DEPTH);
    localparam int OUT_DATA_W     = 4 * OUT_W;

    typedef logic [STEP_W-1:0] t_step;

    // hold conditions: the step repeats while its condition is true
    typedef enum logic [1:0] {
        C_NONE,
        C_WAIT_IN,
        C_R1,
        C_R2
    } t_cond;

    typedef enum logic [3:0] {
        M_NONE,
        M_RX_RX,
        M_RY_RY,
        M_RX2_RY,
        M_ODD_ODD,
        M_RY2_PROD,
        M_YM1_YM1,
        M_RX2_PROD,
        M_RX2_RY2
    } t_mul_sel;

    typedef enum logic [2:0] {
        W_NONE,
        W_RX2,
        W_RY2,
        W_R1_INIT,
        W_P_LOAD,
        W_P_ADD4,
        W_P_SUB4
    } t_wr_sel;

    typedef struct packed {
        t_cond    hold;
        logic     jump;
        t_step    target;
        t_mul_sel mul;
        t_wr_sel  wr;
    } t_ucode;

    typedef struct packed {
        logic     load;
        t_mul_sel mul;
        t_wr_sel  wr;
        logic     step_r1;
        logic     step_r2;
    } t_ctrl;

    typedef struct packed {
        logic in_valid;
        logic r1_go;
        logic r2_go;
        logic out_free;
    } t_status;

    localparam t_step S_IDLE = t_step'(0);
    localparam t_step S_R1   = t_step'(5);
    localparam t_step S_R2   = t_step'(12);

    // control program, one word per step
    function automatic t_ucode ucode_rom(input t_step s);
        t_ucode w;
        w = '{hold: C_NONE, jump: 1'b0, target: S_IDLE, mul: M_NONE, wr: W_NONE};
        unique case (s)
            t_step'(0):  w.hold = C_WAIT_IN;
            t_step'(1):  w.mul  = M_RX_RX;
            t_step'(2):  begin w.mul = M_RY_RY;    w.wr = W_RX2;     end
            t_step'(3):  begin w.mul = M_RX2_RY;   w.wr = W_RY2;     end
            t_step'(4):  w.wr   = W_R1_INIT;
            t_step'(5):  w.hold = C_R1;
            t_step'(6):  w.mul  = M_ODD_ODD;
            t_step'(7):  w.mul  = M_RY2_PROD;
            t_step'(8):  begin w.mul = M_YM1_YM1;  w.wr = W_P_LOAD;  end
            t_step'(9):  w.mul  = M_RX2_PROD;
            t_step'(10): begin w.mul = M_RX2_RY2;  w.wr = W_P_ADD4;  end
            t_step'(11): w.wr   = W_P_SUB4;
            t_step'(12): begin w.hold = C_R2;      w.jump = 1'b1;    end
            default:     begin w.jump = 1'b1;      w.target = S_IDLE; end
        endcase
        return w;
    endfunction

endpackage

FILE: src/mer_useq.sv
// microcode sequencer: step counter, control rom and hold/jump logic
// depends on mer_pkg
module mer_useq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mer_pkg::t_status i_status,
    output mer_pkg::t_ctrl  o_ctrl,
    output logic            o_in_ready
);
    import mer_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_ucode w_word;
    logic   w_hold;

    assign w_word = ucode_rom(r_step);

    always_comb begin
        unique case (w_word.hold)
            C_WAIT_IN: w_hold = !i_status.in_valid;
            C_R1:      w_hold = i_status.r1_go;
            C_R2:      w_hold = i_status.r2_go;
            default:   w_hold = 1'b0;
        endcase
    end

    always_comb begin
        if (w_hold) begin
            n_step = r_step;
        end else if (w_word.jump) begin
            n_step = w_word.target;
        end else begin
            n_step = r_step + t_step'(1);
        end
    end

    assign o_in_ready     = (w_word.hold == C_WAIT_IN);
    assign o_ctrl.load    = (w_word.hold == C_WAIT_IN) && i_status.in_valid;
    assign o_ctrl.mul     = w_word.mul;
    assign o_ctrl.wr      = w_word.wr;
    assign o_ctrl.step_r1 = (w_word.hold == C_R1) && i_status.r1_go && i_status.out_free;
    assign o_ctrl.step_r2 = (w_word.hold == C_R2) && i_status.r2_go && i_status.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

FILE: src/mer_datapath.sv
// datapath: shared multiplier, decision and slope registers, output register
// depends on mer_pkg, driven by the mer_useq control word
module mer_datapath #(
    parameter int MAX_RADIUS = mer_pkg::DEF_MAX_RADIUS,
    parameter int COORD_BITS = mer_pkg::DEF_COORD_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [mer_pkg::RAD_W-1:0]      i_rx,
    input  logic [mer_pkg::RAD_W-1:0]      i_ry,
    input  logic [COORD_BITS-1:0]          i_cx,
    input  logic [COORD_BITS-1:0]          i_cy,
    input  mer_pkg::t_ctrl                 i_ctrl,
    input  logic                           i_in_valid,
    input  logic                           i_out_ready,
    output mer_pkg::t_status               o_status,
    output logic                           o_out_valid,
    output logic [mer_pkg::OUT_DATA_W-1:0] o_out_data,
    output logic                           o_out_last
);
    import mer_pkg::*;

    logic [RAD_W-1:0]      r_rx, r_ry;
    logic [OUT_W-1:0]      r_cx, r_cy;
    logic [SQ_W-1:0]       r_rx2, r_ry2;
    logic [OFF_W-1:0]      r_x;
    logic [Y_W-1:0]        r_y;
    logic [SLOPE_W-1:0]    r_dx, r_dy;
    logic [P_W-1:0]        r_p;
    logic [CNT_W-1:0]      r_n;
    logic [PROD_W-1:0]     r_prod;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic                  r_out_last;

    logic [RAD_W-1:0]      w_rx_c, w_ry_c;
    logic [EXT_W-1:0]      w_cx_ext, w_cy_ext;
    logic [MUL_W-1:0]      w_mul_a, w_mul_b, w_odd, w_ym1;
    logic [Y_W-1:0]        w_ym1_raw;
    logic [PROD_W-1:0]     w_prod;
    logic [P_W-1:0]        w_prod4, w_rx2_4, w_ry2_4, w_dx4, w_dy4;
    logic [SLOPE_W-1:0]    w_dx_inc, w_dy_dec, w_rx2_2, w_ry2_2;
    logic                  w_emit, w_last, w_p_neg, w_p_pos, w_at_limit;
    logic [OUT_W-1:0]      w_x12, w_y12;

    function automatic logic [P_W-1:0] slope_x4(input logic [SLOPE_W-1:0] v);
        logic [P_W-1:0] e;
        e = {{(P_W-SLOPE_W){v[SLOPE_W-1]}}, v};
        return {e[P_W-3:0], 2'b00};
    endfunction

    // radius saturation and coordinate sign extension
    assign w_rx_c   = (i_rx > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : i_rx;
    assign w_ry_c   = (i_ry > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : i_ry;
    assign w_cx_ext = {{(EXT_W-COORD_BITS){i_cx[COORD_BITS-1]}}, i_cx};
    assign w_cy_ext = {{(EXT_W-COORD_BITS){i_cy[COORD_BITS-1]}}, i_cy};

    // multiplier operands
    assign w_odd     = {{(MUL_W-OFF_W-1){1'b0}}, r_x, 1'b1};
    assign w_ym1_raw = r_y - Y_W'(1);
    assign w_ym1     = (r_y == '0) ? MUL_W'(1)
                                   : {{(MUL_W-Y_W+1){1'b0}}, w_ym1_raw[Y_W-2:0]};

    always_comb begin
        case (i_ctrl.mul)
            M_RX_RX: begin
                w_mul_a = MUL_W'(r_rx);
                w_mul_b = MUL_W'(r_rx);
            end
            M_RY_RY: begin
                w_mul_a = MUL_W'(r_ry);
                w_mul_b = MUL_W'(r_ry);
            end
            M_RX2_RY: begin
                w_mul_a = MUL_W'(r_rx2);
                w_mul_b = MUL_W'(r_ry);
            end
            M_ODD_ODD: begin
                w_mul_a = w_odd;
                w_mul_b = w_odd;
            end
            M_RY2_PROD: begin
                w_mul_a = MUL_W'(r_ry2);
                w_mul_b = r_prod[MUL_W-1:0];
            end
            M_YM1_YM1: begin
                w_mul_a = w_ym1;
                w_mul_b = w_ym1;
            end
            M_RX2_PROD: begin
                w_mul_a = MUL_W'(r_rx2);
                w_mul_b = r_prod[MUL_W-1:0];
            end
            M_RX2_RY2: begin
                w_mul_a = MUL_W'(r_rx2);
                w_mul_b = MUL_W'(r_ry2);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod  = w_mul_a * w_mul_b;
    assign w_prod4 = {r_prod[P_W-3:0], 2'b00};

    // incremental terms
    assign w_rx2_2  = {{(SLOPE_W-SQ_W-1){1'b0}}, r_rx2, 1'b0};
    assign w_ry2_2  = {{(SLOPE_W-SQ_W-1){1'b0}}, r_ry2, 1'b0};
    assign w_rx2_4  = {{(P_W-SQ_W-2){1'b0}}, r_rx2, 2'b00};
    assign w_ry2_4  = {{(P_W-SQ_W-2){1'b0}}, r_ry2, 2'b00};
    assign w_dx_inc = r_dx + w_ry2_2;
    assign w_dy_dec = r_dy - w_rx2_2;
    assign w_dx4    = slope_x4(w_dx_inc);
    assign w_dy4    = slope_x4(w_dy_dec);
    assign w_p_neg  = r_p[P_W-1];
    assign w_p_pos  = !r_p[P_W-1] && (r_p != '0);

    assign w_at_limit = (r_n == CNT_W'(RESULT_LIMIT - 1));
    assign w_emit     = i_ctrl.step_r1 || i_ctrl.step_r2;
    assign w_last     = w_at_limit || (i_ctrl.step_r2 && (r_y == '0));

    assign o_status.in_valid = i_in_valid;
    assign o_status.r1_go    = ($signed(r_dx) < $signed(r_dy)) && (r_n < CNT_W'(RESULT_LIMIT));
    assign o_status.r2_go    = !r_y[Y_W-1] && (r_n < CNT_W'(RESULT_LIMIT));
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // algorithm registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul != M_NONE) begin
            r_prod <= w_prod;
        end
        if (i_ctrl.load) begin
            r_rx <= w_rx_c;
            r_ry <= w_ry_c;
            r_cx <= w_cx_ext[OUT_W-1:0];
            r_cy <= w_cy_ext[OUT_W-1:0];
            r_x  <= '0;
            r_y  <= {{(Y_W-RAD_W){1'b0}}, w_ry_c};
            r_dx <= '0;
            r_n  <= '0;
        end
        case (i_ctrl.wr)
            W_RX2:     r_rx2 <= r_prod[SQ_W-1:0];
            W_RY2:     r_ry2 <= r_prod[SQ_W-1:0];
            W_R1_INIT: begin
                r_dy <= {{(SLOPE_W-SQ_W-RAD_W-1){1'b0}}, r_prod[SQ_W+RAD_W-1:0], 1'b0};
                r_p  <= w_ry2_4 - w_prod4 + P_W'(r_rx2);
            end
            W_P_LOAD:  r_p <= r_prod[P_W-1:0];
            W_P_ADD4:  r_p <= r_p + w_prod4;
            W_P_SUB4:  r_p <= r_p - w_prod4;
            default:   ;
        endcase
        if (i_ctrl.step_r1) begin
            r_n  <= r_n + CNT_W'(1);
            r_x  <= r_x + OFF_W'(1);
            r_dx <= w_dx_inc;
            if (w_p_neg) begin
                r_p <= r_p + w_dx4 + w_ry2_4;
            end else begin
                r_y  <= r_y - Y_W'(1);
                r_dy <= w_dy_dec;
                r_p  <= r_p + w_dx4 - w_dy4 + w_ry2_4;
            end
        end
        if (i_ctrl.step_r2) begin
            r_n  <= r_n + CNT_W'(1);
            r_y  <= r_y - Y_W'(1);
            r_dy <= w_dy_dec;
            if (w_p_pos) begin
                r_p <= r_p + w_rx2_4 - w_dy4;
            end else begin
                r_x  <= r_x + OFF_W'(1);
                r_dx <= w_dx_inc;
                r_p  <= r_p + w_dx4 - w_dy4 + w_rx2_4;
            end
        end
    end

    // output register
    assign w_x12 = {{(OUT_W-OFF_W){1'b0}}, r_x};
    assign w_y12 = {{(OUT_W-Y_W){r_y[Y_W-1]}}, r_y};

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data <= {r_cy - w_y12, r_cy + w_y12, r_cx - w_x12, r_cx + w_x12};
            r_out_last <= w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_last  = r_out_last;

endmodule

FILE: src/midpoint_ellipse_rasterizer_top.sv
// first point group comes from the region 1 loop, or from region 2 after its set-up if region 1 is empty
// one command transaction per program pass of n point groups (n <= rx + ry + 1), paced
// by the microcode program around one shared 13x13 multiplier, groups one per cycle while the output is free
// a new command is taken only at the idle step; the last group may still wait downstream
// reset: synchronous active-low i_rst_n returns the step counter to idle and empties
// the output register; datapath registers are loaded per command and need no reset
module midpoint_ellipse_rasterizer_top #(
    parameter int MAX_RADIUS = mer_pkg::DEF_MAX_RADIUS,
    parameter int COORD_BITS = mer_pkg::DEF_COORD_BITS,
    parameter int IN_BYTES   = (2 * mer_pkg::RAD_W + 2 * COORD_BITS + 7) / 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // command stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // radius_x, radius_y, centre_x, centre_y (from bit 0 up), zero padded
    input  logic [8*IN_BYTES-1:0] i_s_tdata,
    // point group stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // x_right, x_left, y_top, y_bottom (from bit 0 up)
    output logic [mer_pkg::OUT_DATA_W-1:0] o_m_tdata,
    // last_point
    output logic                  o_m_tlast
);
    import mer_pkg::*;

`include "midpoint_ellipse_rasterizer_top_assert.svh"

    localparam int CX_LSB = 2 * RAD_W;
    localparam int CY_LSB = CX_LSB + COORD_BITS;

    t_ctrl   w_ctrl;
    t_status w_status;
    logic    w_emit;
    logic    w_in_acc;

    // sequencer walks the control program: set-up products, region 1 loop,
    // region 2 set-up products, region 2 loop, back to idle
    mer_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_status   (w_status),
        .o_ctrl     (w_ctrl),
        .o_in_ready (o_s_tready)
    );

    // datapath holds the decision value scaled by four so that the quarter
    // and half terms of the midpoint tests stay exact integers
    mer_datapath #(
        .MAX_RADIUS (MAX_RADIUS),
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (i_s_tdata[RAD_W-1:0]),
        .i_ry        (i_s_tdata[2*RAD_W-1:RAD_W]),
        .i_cx        (i_s_tdata[CX_LSB +: COORD_BITS]),
        .i_cy        (i_s_tdata[CY_LSB +: COORD_BITS]),
        .i_ctrl      (w_ctrl),
        .i_in_valid  (i_s_tvalid),
        .i_out_ready (i_m_tready),
        .o_status    (w_status),
        .o_out_valid (o_m_tvalid),
        .o_out_data  (o_m_tdata),
        .o_out_last  (o_m_tlast)
    );

    // either region loop produces a point group this cycle
    assign w_emit   = w_ctrl.step_r1 || w_ctrl.step_r2;
    // command transaction this cycle
    assign w_in_acc = i_s_tvalid && o_s_tready;

    // a command transaction always moves the sequencer off the idle step
    `MER_ASSERT_NEXT(a_leave_idle, i_clk, i_rst_n, w_in_acc, !o_s_tready, "still idle after command")
    // a new point group never overwrites one that is still waiting
    `MER_ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, w_emit && o_m_tvalid && !i_m_tready, "overwrite")
    // no point group is produced while waiting for a command
    `MER_ASSERT_NEVER(a_idle_quiet, i_clk, i_rst_n, o_s_tready && w_emit, "group produced while idle")
    // the two region loops are never active together
    `MER_ASSERT_NEVER(a_one_region, i_clk, i_rst_n, w_ctrl.step_r1 && w_ctrl.step_r2, "both regions active")

endmodule
